### sv/aps_pkg.sv
`timescale 1ns / 1ps
// Package for the arm position PID controller with slew limit.
// Holds widths, fixed-point constants, codes, state and command types.
// No dependencies; every other file of the block imports it.
package aps_pkg;

	localparam int CMD_W       = 2;
	localparam int ANGLE_W     = 16;
	localparam int GAIN_W      = 16;
	localparam int ILIM_W      = 16;
	localparam int LIM_W       = 12;
	localparam int VEL_W       = 13;
	localparam int ERR_W       = ANGLE_W + 1;
	localparam int DIFF_W      = ERR_W + 1;
	localparam int INTEG_FRAC  = 8;
	localparam int INTEG_W     = ILIM_W + INTEG_FRAC + 1;
	localparam int IUPD_W      = INTEG_W + 3;
	localparam int ACC_W       = 48;
	localparam int MA_W        = 28;
	localparam int MB_W        = DIFF_W;
	localparam int MP_W        = MA_W + MB_W;
	localparam int FRAC_W      = 18;
	localparam int QUO_W       = 14;
	localparam int QUO_BIAS    = 2 ** (QUO_W - 1);
	localparam int T_W         = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int DECAY_NUM   = 973;
	localparam int DECAY_SH    = 10;
	localparam int DERIV_NUM   = 717;
	localparam int P_SH        = 10;
	localparam int I_SH        = 2;

	localparam int DEAD_ZONE_DEF  = 2;
	localparam int SCALE_SPAN_DEF = 50;

	localparam logic [GAIN_W-1:0] KP_RESET     = 16'd256;
	localparam logic [GAIN_W-1:0] KI_RESET     = 16'd0;
	localparam logic [GAIN_W-1:0] KD_RESET     = 16'd0;
	localparam logic [ILIM_W-1:0] ILIM_RESET   = 16'd2000;
	localparam logic [LIM_W-1:0]  OLIM_RESET   = 12'd600;
	localparam logic [LIM_W-1:0]  SLEW_RESET   = 12'd15;
	localparam logic [LIM_W-1:0]  MSPEED_RESET = 12'd127;
	localparam logic [LIM_W-1:0]  WINDOW_RESET = 12'd20;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK = 2'd0,
		CMD_UP   = 2'd1,
		CMD_DOWN = 2'd2,
		CMD_SET  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP     = 3'd0,
		REG_KI     = 3'd1,
		REG_KD     = 3'd2,
		REG_ILIM   = 3'd3,
		REG_OLIM   = 3'd4,
		REG_SLEW   = 3'd5,
		REG_MSPEED = 3'd6,
		REG_WINDOW = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_INT,
		ST_MUL_KD,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ACC_D,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_NUM,
		ST_PREP,
		ST_DIV,
		ST_FINAL,
		ST_WB
	} state_t;

	typedef enum logic [2:0] {
		MUL_INT,
		MUL_KD,
		MUL_P,
		MUL_I,
		MUL_D,
		MUL_HI,
		MUL_LO
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD2,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [1:0] {
		NUM_HOLD,
		NUM_LOAD,
		NUM_ADD
	} num_op_t;

	typedef struct packed {
		logic                 load_in;
		mul_sel_t             mul_sel;
		logic                 integ_upd;
		logic                 kd_latch;
		acc_op_t              acc_op;
		num_op_t              num_op;
		logic                 div_init;
		logic                 div_step;
		logic                 finish;
		logic                 out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [ILIM_W-1:0] ilim;
		logic [LIM_W-1:0]  olim;
		logic [LIM_W-1:0]  slew;
		logic [LIM_W-1:0]  mspeed;
		logic [LIM_W-1:0]  window;
	} cfg_t;

endpackage

### sv/aps_item_if.sv
`timescale 1ns / 1ps
// Input channel of the controller: command, encoder angle and new target.
// Depends on aps_pkg for the field widths.
interface aps_item_if import aps_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [ANGLE_W-1:0] angle;
	logic signed [ANGLE_W-1:0] new_target;

	modport source (output valid, output cmd, output angle, output new_target, input ready);
	modport sink (input valid, input cmd, input angle, input new_target, output ready);
endinterface

### sv/aps_result_if.sv
`timescale 1ns / 1ps
// Result channel of the controller: velocity, manual flag and held target.
// Depends on aps_pkg for the field widths.
interface aps_result_if import aps_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VEL_W-1:0]   velocity;
	logic                      manual_active;
	logic signed [ANGLE_W-1:0] target_now;

	modport source (output valid, output velocity, output manual_active, output target_now,
		input ready);
	modport sink (input valid, input velocity, input manual_active, input target_now,
		output ready);
endinterface

### sv/aps_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on aps_pkg for the field widths.
interface aps_cfg_if import aps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/aps_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: gains, limits, slew step, manual speed, window.
// Depends on aps_pkg for the register codes and the cfg_t bundle.
module aps_cfg import aps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output logic                  wr_ready,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp     <= KP_RESET;
			cfg_q.ki     <= KI_RESET;
			cfg_q.kd     <= KD_RESET;
			cfg_q.ilim   <= ILIM_RESET;
			cfg_q.olim   <= OLIM_RESET;
			cfg_q.slew   <= SLEW_RESET;
			cfg_q.mspeed <= MSPEED_RESET;
			cfg_q.window <= WINDOW_RESET;
		end else if (wr_valid) begin
			case (cfg_reg_t'(wr_index))
				REG_KP:     cfg_q.kp     <= wr_data[GAIN_W-1:0];
				REG_KI:     cfg_q.ki     <= wr_data[GAIN_W-1:0];
				REG_KD:     cfg_q.kd     <= wr_data[GAIN_W-1:0];
				REG_ILIM:   cfg_q.ilim   <= wr_data[ILIM_W-1:0];
				REG_OLIM:   cfg_q.olim   <= wr_data[LIM_W-1:0];
				REG_SLEW:   cfg_q.slew   <= wr_data[LIM_W-1:0];
				REG_MSPEED: cfg_q.mspeed <= wr_data[LIM_W-1:0];
				REG_WINDOW: cfg_q.window <= wr_data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

### sv/aps_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the controller: steps the shared multiplier, accumulators and
// the reciprocal scaling step of the datapath and owns both handshakes. Depends on aps_pkg.
module aps_ctrl import aps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic [CMD_W-1:0] item_cmd,
	output logic             item_ready,
	output logic             result_valid,
	input  logic             result_ready,
	output dp_cmd_t          dp_cmd
);

	state_t               state_q, state_d;
	logic                 out_valid_q, out_valid_d;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		dp_cmd         = '0;
		dp_cmd.mul_sel = MUL_INT;
		dp_cmd.acc_op  = ACC_HOLD;
		dp_cmd.num_op  = NUM_HOLD;
		out_valid_d    = out_valid_q && !result_ready;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					dp_cmd.load_in = 1'b1;
					state_d = (item_cmd == CMD_TICK) ? ST_MUL_INT : ST_WB;
				end
			end
			ST_MUL_INT: begin
				dp_cmd.mul_sel = MUL_INT;
				state_d = ST_MUL_KD;
			end
			ST_MUL_KD: begin
				dp_cmd.mul_sel   = MUL_KD;
				dp_cmd.integ_upd = 1'b1;
				state_d = ST_MUL_P;
			end
			ST_MUL_P: begin
				dp_cmd.mul_sel  = MUL_P;
				dp_cmd.kd_latch = 1'b1;
				state_d = ST_MUL_I;
			end
			ST_MUL_I: begin
				dp_cmd.mul_sel = MUL_I;
				dp_cmd.acc_op  = ACC_LOAD;
				state_d = ST_MUL_D;
			end
			ST_MUL_D: begin
				dp_cmd.mul_sel = MUL_D;
				dp_cmd.acc_op  = ACC_ADD2;
				state_d = ST_ACC_D;
			end
			ST_ACC_D: begin
				dp_cmd.acc_op = ACC_ADD;
				state_d = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				dp_cmd.mul_sel = MUL_HI;
				state_d = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				dp_cmd.mul_sel = MUL_LO;
				dp_cmd.num_op  = NUM_LOAD;
				state_d = ST_NUM;
			end
			ST_NUM: begin
				dp_cmd.num_op = NUM_ADD;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				dp_cmd.div_init = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				dp_cmd.div_step = 1'b1;
				state_d = ST_FINAL;
			end
			ST_FINAL: begin
				dp_cmd.finish = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				if (!out_valid_q || result_ready) begin
					dp_cmd.out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item_cmd == CMD_TICK) |=> state_q == ST_MUL_INT)
		else $error("accepted tick did not start the multiply sequence");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> state_q == ST_FINAL)
		else $error("scaling step did not end after one cycle");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |=> result_valid)
		else $error("result register loaded but not presented");

endmodule

### sv/aps_dp.sv
`timescale 1ns / 1ps
// Datapath of the controller: loop state, shared multiplier, PID accumulator,
// scale numerator, reciprocal scaling unit, slew/limit stage and result register.
// Depends on aps_pkg for widths, constants and the command bundle.
module aps_dp import aps_pkg::*; #(
	parameter int DEAD_ZONE  = DEAD_ZONE_DEF,
	parameter int SCALE_SPAN = SCALE_SPAN_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   dp_cmd,
	input  cfg_t                      cfg,
	input  logic [CMD_W-1:0]          item_cmd,
	input  logic signed [ANGLE_W-1:0] item_angle,
	input  logic signed [ANGLE_W-1:0] item_new_target,
	output logic signed [VEL_W-1:0]   velocity,
	output logic                      manual_active,
	output logic signed [ANGLE_W-1:0] target_now
);

	localparam int SPAN_W   = $clog2(SCALE_SPAN + 1);
	localparam int NUM_W    = ACC_W + SPAN_W + 2;
	localparam int Y_W      = NUM_W - FRAC_W;
	localparam int REM_W    = SPAN_W + QUO_W;
	localparam int RECIP_SH = REM_W + SPAN_W;
	localparam int RECIP_W  = REM_W + 2;
	localparam int RPROD_W  = REM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((longint'(1) << RECIP_SH)
		+ longint'(SCALE_SPAN) - longint'(1)) / longint'(SCALE_SPAN));

	// Loop state.
	logic signed [ANGLE_W-1:0] target_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [VEL_W-1:0]   prev_out_q;

	// Per-tick working registers.
	logic signed [ERR_W-1:0]   e_q;
	logic [ERR_W-1:0]          ae_q;
	logic signed [DIFF_W-1:0]  d_q;
	logic                      win_q, dead_q, span_q;
	logic [GAIN_W+9:0]         kd717_q;
	logic signed [MP_W-1:0]    prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [NUM_W-1:0]   num_q;
	logic [REM_W-1:0]          rem_q;
	logic [QUO_W-1:0]          quo_q;
	logic signed [VEL_W-1:0]   res_vel_q;
	logic                      res_man_q;
	logic signed [VEL_W-1:0]   out_vel_q;
	logic                      out_man_q;
	logic signed [ANGLE_W-1:0] out_tgt_q;

	logic signed [ERR_W-1:0]   err_w;
	logic [ERR_W-1:0]          ae_w;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [MP_W-1:0]    prod_w;
	logic signed [MP_W-1:0]    dec_full;
	logic signed [IUPD_W-1:0]  grow_w, half_w, cand_w, ilim_s, integ_clamp;
	logic signed [ACC_W-1:0]   prod_acc;
	logic signed [NUM_W-1:0]   prod_num, half_den, x_w;
	logic [SPAN_W-1:0]         div_w, fac;
	logic signed [Y_W-1:0]     y_w, bnd, y_sat;
	logic [RPROD_W-1:0]        rprod_w;
	logic signed [T_W-1:0]     t_w, prev_ext, slew_s, olim_s, chg, slewed, limited;
	logic signed [VEL_W-1:0]   fin_w;

	assign velocity      = out_vel_q;
	assign manual_active = out_man_q;
	assign target_now    = out_tgt_q;

	assign err_w = ERR_W'(target_q) - ERR_W'(item_angle);
	assign ae_w  = err_w[ERR_W-1] ? ERR_W'(-err_w) : ERR_W'(err_w);

	assign div_w = span_q ? SPAN_W'(SCALE_SPAN) : SPAN_W'(1);
	assign fac   = span_q ? ae_q[SPAN_W-1:0] : SPAN_W'(1);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (dp_cmd.mul_sel)
			MUL_INT: begin
				mul_a = MA_W'(integ_q);
				mul_b = MB_W'(DECAY_NUM);
			end
			MUL_KD: begin
				mul_a = MA_W'(DERIV_NUM);
				mul_b = MB_W'(cfg.kd);
			end
			MUL_P: begin
				mul_a = MA_W'(e_q);
				mul_b = MB_W'(cfg.kp);
			end
			MUL_I: begin
				mul_a = MA_W'(integ_q);
				mul_b = MB_W'(cfg.ki);
			end
			MUL_D: begin
				mul_a = MA_W'(kd717_q);
				mul_b = MB_W'(d_q);
			end
			MUL_HI: begin
				mul_a = MA_W'($signed(acc_q[ACC_W-1:ACC_W/2]));
				mul_b = MB_W'(fac);
			end
			MUL_LO: begin
				mul_a = MA_W'(acc_q[ACC_W/2-1:0]);
				mul_b = MB_W'(fac);
			end
			default: begin
			end
		endcase
	end

	assign prod_w = mul_a * mul_b;

	// Integral update: decay and add inside the window, halve outside, then clamp.
	assign dec_full = (prod_q + MP_W'(2 ** (DECAY_SH - 1))) >>> DECAY_SH;
	assign grow_w   = IUPD_W'(dec_full) + (IUPD_W'(e_q) <<< INTEG_FRAC);
	assign half_w   = (IUPD_W'(integ_q) + IUPD_W'(1)) >>> 1;
	assign cand_w   = win_q ? grow_w : half_w;
	assign ilim_s   = IUPD_W'({cfg.ilim, {INTEG_FRAC{1'b0}}});

	always_comb begin
		if (cand_w > ilim_s) begin
			integ_clamp = ilim_s;
		end else if (cand_w < -ilim_s) begin
			integ_clamp = -ilim_s;
		end else begin
			integ_clamp = cand_w;
		end
	end

	assign prod_acc = ACC_W'(prod_q);
	assign prod_num = NUM_W'(prod_q);

	// Rounded scale: floor((num + S*2^17) / 2^18) then floor division by S,
	// with the quotient saturated to its biased range. The division by S is an
	// exact multiply by the rounded-up reciprocal of S.
	assign half_den = NUM_W'(div_w) << (FRAC_W - 1);
	assign x_w      = num_q + half_den;
	assign y_w      = x_w[NUM_W-1:FRAC_W];
	assign bnd      = Y_W'(div_w) << (QUO_W - 1);

	always_comb begin
		if (y_w >= bnd) begin
			y_sat = bnd - Y_W'(1);
		end else if (y_w < -bnd) begin
			y_sat = -bnd;
		end else begin
			y_sat = y_w;
		end
	end

	assign rprod_w = RPROD_W'(rem_q) * RPROD_W'(RECIP);

	// Slew limit, output clamp and dead zone.
	assign t_w      = $signed(T_W'(quo_q)) - T_W'(QUO_BIAS);
	assign prev_ext = T_W'(prev_out_q);
	assign slew_s   = T_W'(cfg.slew);
	assign olim_s   = T_W'(cfg.olim);
	assign chg      = t_w - prev_ext;

	always_comb begin
		if (chg > slew_s) begin
			slewed = prev_ext + slew_s;
		end else if (chg < -slew_s) begin
			slewed = prev_ext - slew_s;
		end else begin
			slewed = t_w;
		end
		if (slewed > olim_s) begin
			limited = olim_s;
		end else if (slewed < -olim_s) begin
			limited = -olim_s;
		end else begin
			limited = slewed;
		end
		fin_w = dead_q ? '0 : VEL_W'(limited);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			integ_q    <= '0;
			prev_err_q <= '0;
			prev_out_q <= '0;
		end else begin
			if (dp_cmd.load_in) begin
				case (cmd_t'(item_cmd))
					CMD_UP, CMD_DOWN: begin
						target_q   <= item_angle;
						integ_q    <= '0;
						prev_err_q <= '0;
						prev_out_q <= '0;
					end
					CMD_SET: begin
						target_q <= item_new_target;
					end
					default: begin
					end
				endcase
			end
			if (dp_cmd.integ_upd) begin
				integ_q <= INTEG_W'(integ_clamp);
			end
			if (dp_cmd.finish) begin
				prev_err_q <= e_q;
				prev_out_q <= fin_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_w;
		if (dp_cmd.load_in) begin
			e_q       <= err_w;
			ae_q      <= ae_w;
			d_q       <= DIFF_W'(err_w) - DIFF_W'(prev_err_q);
			win_q     <= ae_w < ERR_W'(cfg.window);
			dead_q    <= ae_w < ERR_W'(DEAD_ZONE);
			span_q    <= ae_w < ERR_W'(SCALE_SPAN);
			res_man_q <= (item_cmd == CMD_UP) || (item_cmd == CMD_DOWN);
			case (cmd_t'(item_cmd))
				CMD_UP:   res_vel_q <= VEL_W'(cfg.mspeed);
				CMD_DOWN: res_vel_q <= -VEL_W'(cfg.mspeed);
				default:  res_vel_q <= '0;
			endcase
		end
		if (dp_cmd.kd_latch) begin
			kd717_q <= (GAIN_W+10)'(prod_q);
		end
		case (dp_cmd.acc_op)
			ACC_LOAD: acc_q <= prod_acc <<< P_SH;
			ACC_ADD2: acc_q <= acc_q + (prod_acc <<< I_SH);
			ACC_ADD:  acc_q <= acc_q + prod_acc;
			default: begin
			end
		endcase
		case (dp_cmd.num_op)
			NUM_LOAD: num_q <= prod_num <<< (ACC_W / 2);
			NUM_ADD:  num_q <= num_q + prod_num;
			default: begin
			end
		endcase
		if (dp_cmd.div_init) begin
			rem_q <= REM_W'(y_sat + bnd);
		end else if (dp_cmd.div_step) begin
			quo_q <= span_q ? rprod_w[RECIP_SH +: QUO_W] : rem_q[QUO_W-1:0];
		end
		if (dp_cmd.finish) begin
			res_vel_q <= fin_w;
		end
		if (dp_cmd.out_load) begin
			out_vel_q <= res_vel_q;
			out_man_q <= res_man_q;
			out_tgt_q <= target_q;
		end
	end

	a_integ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.integ_upd |=> (IUPD_W'(integ_q) <= ilim_s) && (IUPD_W'(integ_q) >= -ilim_s))
		else $error("integral left its clamp range");

	a_vel_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.finish |=> (T_W'(res_vel_q) <= olim_s) && (T_W'(res_vel_q) >= -olim_s))
		else $error("tick velocity exceeds the output limit");

	a_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.div_step |-> {1'b0, rem_q} < ((REM_W+1)'(div_w) << QUO_W))
		else $error("quotient remainder out of range");

endmodule

### sv/arm_position_pid_with_slew.sv
`timescale 1ns / 1ps
// Control tick: the result shows as the sequencer returns to idle and can take the next item.
// The tick time is set by nine steps of the shared 28x18 multiplier and accumulators, one
// saturation step, one reciprocal multiply for the error scaling, the slew stage and the
// result load. Manual and set-target items go straight to the result load.
// An item is accepted while the previous result still waits in the output register.
// Reset (arst_n low) clears target, integral, last error and last output to zero and loads
// the register defaults; there is no clearing pass.
module arm_position_pid_with_slew import aps_pkg::*; #(
	parameter int DEAD_ZONE  = DEAD_ZONE_DEF,
	parameter int SCALE_SPAN = SCALE_SPAN_DEF
) (
	input logic          clk,
	input logic          arst_n,
	aps_item_if.sink     item,
	aps_result_if.source result,
	aps_cfg_if.sink      cfg
);

	dp_cmd_t dp_cmd;
	cfg_t    cfg_regs;

	aps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.wr_ready (cfg.ready),
		.cfg      (cfg_regs)
	);

	aps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_cmd     (item.cmd),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.dp_cmd       (dp_cmd)
	);

	aps_dp #(
		.DEAD_ZONE  (DEAD_ZONE),
		.SCALE_SPAN (SCALE_SPAN)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.dp_cmd          (dp_cmd),
		.cfg             (cfg_regs),
		.item_cmd        (item.cmd),
		.item_angle      (item.angle),
		.item_new_target (item.new_target),
		.velocity        (result.velocity),
		.manual_active   (result.manual_active),
		.target_now      (result.target_now)
	);

endmodule
